/* sv/clock_digit_bitmap_scroller_unit_assert.svh */
// Assertion macros used by the clock digit bitmap scroller checker.
`ifndef CLOCK_DIGIT_BITMAP_SCROLLER_UNIT_ASSERT_SVH
`define CLOCK_DIGIT_BITMAP_SCROLLER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define CDBS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cdbs assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define CDBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cdbs assertion failed");

`endif

/* sv/cdbs_pkg.sv */
// Package: widths, opcodes, layout constants and glyph font for the bitmap scroller.
`default_nettype none
package cdbs_pkg;

    localparam int ROW_COUNT  = 8;
    localparam int ROW_W      = 64;
    localparam int BYTE_W     = 8;
    localparam int POS_W      = 6;
    localparam int HOUR_W     = 5;
    localparam int MINUTE_W   = 6;
    localparam int S_DATA_W   = 16;
    localparam int S_USER_W   = 1;
    localparam int M_DATA_W   = ROW_COUNT * BYTE_W;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [POS_W-1:0] START_POS = 6'd48;
    localparam logic [POS_W-1:0] ADV_ONE   = 6'd4;
    localparam logic [POS_W-1:0] ADV_DIGIT = 6'd7;
    localparam logic [POS_W-1:0] ADV_COLON = 6'd3;

    localparam logic [HOUR_W-1:0] NOON = 5'd12;

    localparam logic [BYTE_W-1:0] COLON_DOT   = 8'h80;
    localparam int                COLON_ROW_A = 2;
    localparam int                COLON_ROW_B = 5;

    typedef logic [ROW_COUNT-1:0][ROW_W-1:0] row_set_t;

    // Glyph byte for one row of a digit; row 0 sits in the low byte of each word.
    function automatic logic [BYTE_W-1:0] glyph_row(input logic [3:0] digit,
                                                    input logic [2:0] row);
        logic [ROW_W-1:0] g;
        case (digit)
            4'd0:    g = 64'h7088_8888_8888_8870;
            4'd1:    g = 64'h4040_4040_4040_c040;
            4'd2:    g = 64'hf880_4020_1088_8870;
            4'd3:    g = 64'h7088_0808_3008_8870;
            4'd4:    g = 64'h0808_f888_4828_1808;
            4'd5:    g = 64'h7088_0808_f080_80f8;
            4'd6:    g = 64'h7088_8888_f080_8070;
            4'd7:    g = 64'h2020_2010_1008_08f8;
            4'd8:    g = 64'h7088_8888_7088_8870;
            4'd9:    g = 64'h7008_0878_8888_8870;
            default: g = '0;
        endcase
        return g[{row, 3'b000} +: BYTE_W];
    endfunction

endpackage
`default_nettype wire

/* sv/cdbs_render.sv */
// Time renderer: draws H:MM / HH:MM into a fresh set of eight row bitmaps.
`default_nettype none
module cdbs_render
(
    input  wire logic [cdbs_pkg::HOUR_W-1:0]   hour,
    input  wire logic [cdbs_pkg::MINUTE_W-1:0] minute,
    output      cdbs_pkg::row_set_t            rows
);
    import cdbs_pkg::*;

    logic [HOUR_W-1:0]   hour_adj;
    logic                h_tens;
    logic [3:0]          h_ones;
    logic [2:0]          m_tens;
    logic [MINUTE_W-1:0] m_tens_x10;
    logic [3:0]          m_ones;
    logic [POS_W-1:0]    pos_h0;
    logic [POS_W-1:0]    pos_col;
    logic [POS_W-1:0]    pos_m1;
    logic [POS_W-1:0]    pos_m0;
    logic [HOUR_W-1:0]   h_ones_full;
    logic [MINUTE_W-1:0] m_ones_full;

    assign hour_adj    = (hour > NOON) ? hour - NOON : hour;
    assign h_tens      = (hour_adj >= 5'd10);
    assign h_ones_full = h_tens ? hour_adj - 5'd10 : hour_adj;
    assign h_ones      = h_ones_full[3:0];

    always_comb
    begin
        if (minute >= 6'd60)
        begin
            m_tens = 3'd6;
            m_tens_x10 = 6'd60;
        end
        else if (minute >= 6'd50)
        begin
            m_tens = 3'd5;
            m_tens_x10 = 6'd50;
        end
        else if (minute >= 6'd40)
        begin
            m_tens = 3'd4;
            m_tens_x10 = 6'd40;
        end
        else if (minute >= 6'd30)
        begin
            m_tens = 3'd3;
            m_tens_x10 = 6'd30;
        end
        else if (minute >= 6'd20)
        begin
            m_tens = 3'd2;
            m_tens_x10 = 6'd20;
        end
        else if (minute >= 6'd10)
        begin
            m_tens = 3'd1;
            m_tens_x10 = 6'd10;
        end
        else
        begin
            m_tens = 3'd0;
            m_tens_x10 = 6'd0;
        end
    end

    assign m_ones_full = minute - m_tens_x10;
    assign m_ones      = m_ones_full[3:0];

    // A suppressed leading zero still takes the full digit advance.
    assign pos_h0  = START_POS - (h_tens ? ADV_ONE : ADV_DIGIT);
    assign pos_col = pos_h0 - ((h_ones == 4'd1) ? ADV_ONE : ADV_DIGIT);
    assign pos_m1  = pos_col - ADV_COLON;
    assign pos_m0  = pos_m1 - ((m_tens == 3'd1) ? ADV_ONE : ADV_DIGIT);

    always_comb
    begin
        for (int r = 0; r < ROW_COUNT; r++)
        begin
            rows[r] = (ROW_W'(glyph_row(4'(m_ones), 3'(r))) << pos_m0)
                    | (ROW_W'(glyph_row({1'b0, m_tens}, 3'(r))) << pos_m1)
                    | (ROW_W'(glyph_row(h_ones, 3'(r))) << pos_h0);
            if (h_tens)
            begin
                rows[r] = rows[r] | (ROW_W'(glyph_row(4'd1, 3'(r))) << START_POS);
            end
            if (r == COLON_ROW_A || r == COLON_ROW_B)
            begin
                rows[r] = rows[r] | (ROW_W'(COLON_DOT) << pos_col);
            end
        end
    end

endmodule
`default_nettype wire

/* sv/clock_digit_bitmap_scroller_unit.sv */
// Clock digit bitmap scroller: renders a time into eight row bitmaps and scrolls them out.
//
// Slave channel: one beat per item. tuser[0] is the opcode (0 = load, 1 = tick);
// tdata carries hour (bits 4:0) and minute (bits 10:5).
// A load beat clears the eight 64-bit rows and draws the time; it returns nothing.
// A tick beat returns one master beat with the top byte of rows 0..7 (row 0 in
// m_tdata[7:0]) and then shifts every row left by one.
// An accepted beat lands in the input register and is processed from there; a tick's
// result goes into the result register, which drives m_tdata and m_tvalid.
// Throughput: one beat per cycle while the master side keeps up, loads and ticks mixed
// freely; the bitmap update and the font lookup are combinational between the registers.
// When the master side stalls, the result register holds its beat and one more tick
// waits in the input register; s_tready drops only then. Loads keep flowing past a
// held result since they produce no beat.
// Reset clears the bitmap to all zeros and empties both registers.
`default_nettype none
module clock_digit_bitmap_scroller_unit
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output      logic                            s_tready,
    input  wire logic [cdbs_pkg::S_DATA_W-1:0]   s_tdata,   // hour[4:0], minute[10:5], zero pad
    input  wire logic [cdbs_pkg::S_USER_W-1:0]   s_tuser,   // opcode[0]
    output      logic                            m_tvalid,
    input  wire logic                            m_tready,
    output      logic [cdbs_pkg::M_DATA_W-1:0]   m_tdata    // row0[7:0] .. row7[63:56]
);
    import cdbs_pkg::*;

    logic                in_valid_reg;
    logic                in_valid_next;
    logic                op_reg;
    logic [HOUR_W-1:0]   hour_reg;
    logic [MINUTE_W-1:0] minute_reg;
    row_set_t            rows_reg;
    row_set_t            rows_next;
    row_set_t            rows_load;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [M_DATA_W-1:0] out_data_reg;
    logic [M_DATA_W-1:0] out_data_next;
    logic                s_beat;
    logic                adv;

    cdbs_render u_render
    (
        .hour   (hour_reg),
        .minute (minute_reg),
        .rows   (rows_load)
    );

    assign adv      = in_valid_reg && (op_reg == OP_LOAD || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;
    assign s_beat   = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_beat)
        begin
            in_valid_next = 1'b1;
        end
        else if (adv)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        rows_next      = rows_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        if (adv)
        begin
            if (op_reg == OP_LOAD)
            begin
                rows_next = rows_load;
            end
            else
            begin
                out_valid_next = 1'b1;
                for (int r = 0; r < ROW_COUNT; r++)
                begin
                    out_data_next[r*BYTE_W +: BYTE_W] = rows_reg[r][ROW_W-1 -: BYTE_W];
                    rows_next[r] = {rows_reg[r][ROW_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            rows_reg      <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            rows_reg      <= rows_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_beat)
        begin
            op_reg     <= s_tuser[0];
            hour_reg   <= s_tdata[HOUR_W-1:0];
            minute_reg <= s_tdata[HOUR_W +: MINUTE_W];
        end
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
`default_nettype wire

/* sv/cdbs_checker.sv */
// Port-level checker for the bitmap scroller, bound to the top level.
`default_nettype none
`include "clock_digit_bitmap_scroller_unit_assert.svh"
module cdbs_checker
(
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic [cdbs_pkg::S_DATA_W-1:0] s_tdata,
    input wire logic [cdbs_pkg::S_USER_W-1:0] s_tuser,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [cdbs_pkg::M_DATA_W-1:0] m_tdata
);
    import cdbs_pkg::*;

    logic tick_beat;
    logic pad_zero;

    assign tick_beat = s_tvalid && s_tready && s_tuser[0] == OP_TICK;
    assign pad_zero  = (s_tdata[S_DATA_W-1:HOUR_W+MINUTE_W] == '0);

    `CDBS_ASSERT_NEXT(a_hold_stall, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `CDBS_ASSERT_IMPL(a_ready_when_empty, clk, rst_n, !m_tvalid, s_tready)
    `CDBS_ASSERT_IMPL(a_rise_from_tick, clk, rst_n, $rose(m_tvalid), $past(tick_beat, 2))
    `CDBS_ASSERT_IMPL(a_beat_known, clk, rst_n, m_tvalid, !$isunknown(m_tdata))
    `CDBS_ASSERT_IMPL(a_pad_zero, clk, rst_n, s_tvalid, pad_zero)

endmodule

bind clock_digit_bitmap_scroller_unit cdbs_checker u_cdbs_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
